### rtl/hae_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the heartbeat arrival estimator
package hae_pkg;

    localparam int WINDOW_SIZE = 5;
    localparam int IDX_W       = $clog2(WINDOW_SIZE);
    localparam int REM_W       = $clog2(WINDOW_SIZE);
    localparam int TIME_W      = 64;
    localparam int SEQ_W       = 32;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STAGES  = TIME_W / DIV_BITS;

    localparam logic [15:0] MIN_FRAME_BYTES      = 16'd50;
    localparam logic [15:0] ETHER_TYPE_IPV4      = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP         = 8'd17;
    localparam logic [15:0] WATCH_PORT_RESET     = 16'd8888;

    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_WATCH_PORT = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FILL,
        KIND_FILL_LAST,
        KIND_SLIDE
    } kind_t;

    typedef struct packed {
        logic  drop;
        kind_t kind;
    } meta_t;

    typedef struct packed {
        meta_t              meta;
        logic [TIME_W-1:0]  value;
    } stage_t;

    typedef struct packed {
        meta_t              meta;
        logic [TIME_W-1:0]  raw;
        logic [TIME_W-1:0]  quot;
    } div_item_t;

endpackage

### rtl/hae_in_if.sv
`timescale 1ns / 1ps
// frame summary request channel
interface hae_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [15:0] udp_dest_port;
    logic [31:0] heartbeat_sequence;
    logic [63:0] arrival_time_ns;

    modport source (
        output valid, frame_length, ether_type, ip_protocol, udp_dest_port,
               heartbeat_sequence, arrival_time_ns,
        input  ready
    );
    modport sink (
        input  valid, frame_length, ether_type, ip_protocol, udp_dest_port,
               heartbeat_sequence, arrival_time_ns,
        output ready
    );
endinterface

### rtl/hae_out_if.sv
`timescale 1ns / 1ps
// result request channel
interface hae_out_if;
    logic        valid;
    logic        ready;
    logic        drop_frame;
    logic        heartbeat_accepted;
    logic        estimate_valid;
    logic [63:0] arrival_estimate_ns;

    modport source (
        output valid, drop_frame, heartbeat_accepted, estimate_valid,
               arrival_estimate_ns,
        input  ready
    );
    modport sink (
        input  valid, drop_frame, heartbeat_accepted, estimate_valid,
               arrival_estimate_ns,
        output ready
    );
endinterface

### rtl/heartbeat_arrival_estimator.sv
`timescale 1ns / 1ps
// Heartbeat arrival estimator: one frame summary request is taken per clock while
// the result side does not stall, and every request yields exactly one result, in
// order, passing through the accept stage with the ring read, the difference or
// fill-sum stage, eight divider stages and the result register.
// The timestamp ring is a single memory written and read at the same slot in the
// accept cycle, and the divide by the window size runs as a pipeline of
// compare-subtract stages, so neither limits throughput. Stalls on the result
// side fill pipeline bubbles before they reach the input. The watched UDP port
// register sits at byte address 0 of the APB port and should only be written
// while no request is in flight.
module heartbeat_arrival_estimator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hae_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    hae_in_if.sink                      frame_in,
    hae_out_if.source                   result_out
);
    import hae_pkg::*;

    logic [15:0]            watch_port_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   cfg_write;

    logic                   front_valid;
    logic                   front_ready;
    stage_t                 front_item;
    logic                   div_valid;
    logic                   div_ready;
    div_item_t              div_item;

    assign reg_idx   = paddr[PADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_port_reg <= WATCH_PORT_RESET;
        end
        else if (cfg_write && (reg_idx == REG_WATCH_PORT))
        begin
            watch_port_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WATCH_PORT: prdata = {16'd0, watch_port_reg};
            default:        prdata = '0;
        endcase
    end

    hae_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .watch_port (watch_port_reg),
        .frame_in   (frame_in),
        .out_valid  (front_valid),
        .out_ready  (front_ready),
        .out_item   (front_item)
    );

    hae_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    hae_tail u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_item    (div_item),
        .result_out (result_out)
    );

endmodule

### rtl/hae_front.sv
`timescale 1ns / 1ps
// classification, sequence check, timestamp ring and fill sum
module hae_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     watch_port,
    hae_in_if.sink          frame_in,
    output logic            out_valid,
    input  logic            out_ready,
    output hae_pkg::stage_t out_item
);
    import hae_pkg::*;

    logic [TIME_W-1:0] ring_mem [WINDOW_SIZE];
    logic [TIME_W-1:0] oldest_reg;

    logic [SEQ_W-1:0]  last_seq_reg;
    logic              any_seen_reg;
    logic [IDX_W-1:0]  widx_reg;
    logic [IDX_W-1:0]  widx_next;
    logic              filled_reg;

    logic              a_valid_reg;
    meta_t             a_meta_reg;
    logic [TIME_W-1:0] a_time_reg;

    logic              b_valid_reg;
    stage_t            b_item_reg;
    logic [TIME_W-1:0] sum_reg;
    logic [TIME_W-1:0] sum_next;

    logic              is_hb;
    logic              hb_accept;
    logic              accept_in;
    logic              a_ready;
    logic              b_load;
    kind_t             kind_in;
    logic [TIME_W-1:0] b_value;

    always_comb
    begin
        is_hb = (frame_in.frame_length >= MIN_FRAME_BYTES) &&
                (frame_in.ether_type == ETHER_TYPE_IPV4) &&
                (frame_in.ip_protocol == IP_PROTO_UDP) &&
                (frame_in.udp_dest_port == watch_port);
        hb_accept = is_hb &&
                    (!any_seen_reg || (frame_in.heartbeat_sequence > last_seq_reg));
        if (!hb_accept)
        begin
            kind_in = KIND_NONE;
        end
        else if (filled_reg)
        begin
            kind_in = KIND_SLIDE;
        end
        else if (widx_reg == IDX_W'(WINDOW_SIZE - 1))
        begin
            kind_in = KIND_FILL_LAST;
        end
        else
        begin
            kind_in = KIND_FILL;
        end
        widx_next = (widx_reg == IDX_W'(WINDOW_SIZE - 1)) ? '0 : widx_reg + IDX_W'(1);
    end

    assign b_load         = a_valid_reg && (!b_valid_reg || out_ready);
    assign a_ready        = !a_valid_reg || b_load;
    assign frame_in.ready = a_ready;
    assign accept_in      = frame_in.valid && a_ready;

    // estimator bookkeeping is settled at accept time, in request order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seq_reg <= '0;
            any_seen_reg <= 1'b0;
            widx_reg     <= '0;
            filled_reg   <= 1'b0;
        end
        else if (accept_in && hb_accept)
        begin
            last_seq_reg <= frame_in.heartbeat_sequence;
            any_seen_reg <= 1'b1;
            widx_reg     <= widx_next;
            if (kind_in == KIND_FILL_LAST)
            begin
                filled_reg <= 1'b1;
            end
        end
    end

    // ring: old entry is read in the same cycle the new timestamp lands
    always_ff @(posedge clk)
    begin
        if (accept_in && hb_accept)
        begin
            ring_mem[widx_reg] <= frame_in.arrival_time_ns;
            if (filled_reg)
            begin
                oldest_reg <= ring_mem[widx_reg];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (accept_in)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (b_load)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            a_meta_reg.drop <= is_hb;
            a_meta_reg.kind <= kind_in;
            a_time_reg      <= frame_in.arrival_time_ns;
        end
    end

    assign sum_next = sum_reg + a_time_reg;

    always_comb
    begin
        case (a_meta_reg.kind) inside
            KIND_SLIDE:                b_value = a_time_reg - oldest_reg;
            KIND_FILL, KIND_FILL_LAST: b_value = sum_next;
            default:                   b_value = sum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            if (b_load)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_load && ((a_meta_reg.kind == KIND_FILL) ||
                           (a_meta_reg.kind == KIND_FILL_LAST)))
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_item_reg.meta  <= a_meta_reg;
            b_item_reg.value <= b_value;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

    a_seq_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && hb_accept |=>
            any_seen_reg && (last_seq_reg == $past(frame_in.heartbeat_sequence)))
        else $error("accepted sequence not recorded");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && (kind_in == KIND_FILL_LAST) |=> filled_reg && (widx_reg == '0))
        else $error("window fill did not complete");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !b_load |=> a_valid_reg && $stable(a_time_reg))
        else $error("stalled request lost");

endmodule

### rtl/hae_div.sv
`timescale 1ns / 1ps
// pipelined divider by the window size, a byte of quotient per stage
module hae_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hae_pkg::stage_t    in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output hae_pkg::div_item_t out_item
);
    import hae_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [TIME_W-1:0] word;
    } div_state_t;

    localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(WINDOW_SIZE);

    // restoring steps; dividend bits shift out the top, quotient bits in
    function automatic div_state_t div_step(input div_state_t s);
        div_state_t     r;
        logic [REM_W:0] wide;
        r = s;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            wide   = {r.rem, r.word[TIME_W-1]};
            r.word = {r.word[TIME_W-2:0], 1'b0};
            if (wide >= DIVISOR)
            begin
                wide      = wide - DIVISOR;
                r.word[0] = 1'b1;
            end
            r.rem = wide[REM_W-1:0];
        end
        return r;
    endfunction

    logic              stg_valid_reg [DIV_STAGES];
    meta_t             stg_meta_reg  [DIV_STAGES];
    logic [TIME_W-1:0] stg_raw_reg   [DIV_STAGES];
    div_state_t        stg_state_reg [DIV_STAGES];
    logic              rdy           [DIV_STAGES+1];

    assign rdy[DIV_STAGES] = out_ready;
    assign in_ready        = rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic              src_valid;
        meta_t             src_meta;
        logic [TIME_W-1:0] src_raw;
        div_state_t        src_state;
        logic              load;

        if (k == 0)
        begin : g_first
            assign src_valid      = in_valid;
            assign src_meta       = in_item.meta;
            assign src_raw        = in_item.value;
            assign src_state.rem  = '0;
            assign src_state.word = in_item.value;
        end
        else
        begin : g_next
            assign src_valid = stg_valid_reg[k-1];
            assign src_meta  = stg_meta_reg[k-1];
            assign src_raw   = stg_raw_reg[k-1];
            assign src_state = stg_state_reg[k-1];
        end

        assign rdy[k] = !stg_valid_reg[k] || rdy[k+1];
        assign load   = src_valid && rdy[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stg_valid_reg[k] <= 1'b0;
            end
            else if (load)
            begin
                stg_valid_reg[k] <= 1'b1;
            end
            else if (rdy[k+1])
            begin
                stg_valid_reg[k] <= 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                stg_meta_reg[k]  <= src_meta;
                stg_raw_reg[k]   <= src_raw;
                stg_state_reg[k] <= div_step(src_state);
            end
        end
    end

    assign out_valid     = stg_valid_reg[DIV_STAGES-1];
    assign out_item.meta = stg_meta_reg[DIV_STAGES-1];
    assign out_item.raw  = stg_raw_reg[DIV_STAGES-1];
    assign out_item.quot = stg_state_reg[DIV_STAGES-1].word;

endmodule

### rtl/hae_tail.sv
`timescale 1ns / 1ps
// running estimate accumulator and result register
module hae_tail (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hae_pkg::div_item_t in_item,
    hae_out_if.source          result_out
);
    import hae_pkg::*;

    logic [TIME_W-1:0] acc_reg;
    logic [TIME_W-1:0] acc_next;
    logic              filled_reg;
    logic              filled_next;
    logic              out_valid_reg;
    logic              out_drop_reg;
    logic              out_accepted_reg;
    logic              out_est_valid_reg;
    logic [TIME_W-1:0] out_est_reg;
    logic              load;

    assign in_ready = !out_valid_reg || result_out.ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        acc_next    = acc_reg;
        filled_next = filled_reg;
        case (in_item.meta.kind)
            KIND_FILL:
            begin
                acc_next = in_item.raw;
            end
            KIND_FILL_LAST:
            begin
                acc_next    = in_item.quot;
                filled_next = 1'b1;
            end
            KIND_SLIDE:
            begin
                acc_next = acc_reg + in_item.quot;
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                acc_reg       <= acc_next;
                filled_reg    <= filled_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_drop_reg      <= in_item.meta.drop;
            out_accepted_reg  <= (in_item.meta.kind != KIND_NONE);
            out_est_valid_reg <= filled_next;
            out_est_reg       <= acc_next;
        end
    end

    assign result_out.valid               = out_valid_reg;
    assign result_out.drop_frame          = out_drop_reg;
    assign result_out.heartbeat_accepted  = out_accepted_reg;
    assign result_out.estimate_valid      = out_est_valid_reg;
    assign result_out.arrival_estimate_ns = out_est_reg;

    a_slide_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && (in_item.meta.kind == KIND_SLIDE) |-> filled_reg)
        else $error("sliding update ahead of the first average");

    a_valid_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_est_valid_reg == filled_reg) && (out_est_reg == acc_reg))
        else $error("result out of step with estimator state");

    a_none_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        load && (in_item.meta.kind == KIND_NONE) |=> acc_reg == $past(acc_reg))
        else $error("estimate moved on a non-accepted frame");

endmodule

### tb/heartbeat_arrival_estimator_test.sv
`timescale 1ns / 1ps
// self-checking testbench of the heartbeat arrival estimator
module heartbeat_arrival_estimator_test;
    import hae_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE      = 30;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 420;
    localparam logic [PADDR_W-1:0] PORT_ADDR = PADDR_W'({REG_WATCH_PORT, 2'b00});

    typedef struct packed {
        logic [15:0]       len;
        logic [15:0]       etype;
        logic [7:0]        proto;
        logic [15:0]       dport;
        logic [SEQ_W-1:0]  seq_no;
        logic [TIME_W-1:0] stamp;
    } frame_t;

    typedef struct packed {
        logic              drop;
        logic              taken;
        logic              est_valid;
        logic [TIME_W-1:0] estimate;
    } frame_result_t;

    // tracks the sliding arrival window and holds the results still owed by the block
    class estimate_tracker;
        logic [15:0]       port;
        logic [SEQ_W-1:0]  last_seq;
        bit                any_seen;
        logic [TIME_W-1:0] accum;
        logic [TIME_W-1:0] ring [WINDOW_SIZE];
        int                slot;
        bit                filled;
        frame_result_t     due_results [$];
        int                mismatches;
        int                frames;
        int                taken;
        int                rejected;
        int                passed;
        int                slides;

        function new();
            port       = WATCH_PORT_RESET;
            last_seq   = '0;
            any_seen   = 1'b0;
            accum      = '0;
            slot       = 0;
            filled     = 1'b0;
            mismatches = 0;
            frames     = 0;
            taken      = 0;
            rejected   = 0;
            passed     = 0;
            slides     = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        function void take_frame(frame_t f);
            frame_result_t r;
            logic [TIME_W-1:0] step_ns;
            bit is_hb;
            is_hb = f.len >= MIN_FRAME_BYTES && f.etype == ETHER_TYPE_IPV4 &&
                    f.proto == IP_PROTO_UDP && f.dport == port;
            r.drop  = is_hb;
            r.taken = 1'b0;
            frames++;
            if (!is_hb)
                passed++;
            else if (any_seen && f.seq_no <= last_seq)
                rejected++;
            else
            begin
                r.taken  = 1'b1;
                taken++;
                any_seen = 1'b1;
                last_seq = f.seq_no;
                if (!filled)
                begin
                    ring[slot] = f.stamp;
                    accum += f.stamp;
                    slot++;
                    if (slot == WINDOW_SIZE)
                    begin
                        accum  = accum / 64'(WINDOW_SIZE);
                        filled = 1'b1;
                        slot   = 0;
                    end
                end
                else
                begin
                    // difference wraps modulo 2^64 before the divide
                    step_ns    = f.stamp - ring[slot];
                    ring[slot] = f.stamp;
                    accum += step_ns / 64'(WINDOW_SIZE);
                    slot = (slot + 1) % WINDOW_SIZE;
                    slides++;
                end
            end
            r.est_valid = filled;
            r.estimate  = accum;
            due_results.push_back(r);
        endfunction

        task match_result(frame_result_t got);
            frame_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result with nothing expected, estimate %h", got.estimate));
                return;
            end
            want = due_results.pop_front();
            if (got.drop !== want.drop)
                report($sformatf("drop_frame %b, expected %b", got.drop, want.drop));
            if (got.taken !== want.taken)
                report($sformatf("heartbeat_accepted %b, expected %b", got.taken, want.taken));
            if (got.est_valid !== want.est_valid)
                report($sformatf("estimate_valid %b, expected %b",
                                 got.est_valid, want.est_valid));
            if (got.estimate !== want.estimate)
                report($sformatf("arrival_estimate_ns %h, expected %h",
                                 got.estimate, want.estimate));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hae_in_if  frame_ch ();
    hae_out_if result_ch ();

    estimate_tracker board;

    logic [15:0]       cur_port = WATCH_PORT_RESET;
    logic [32:0]       seq_cursor = '0;
    logic [TIME_W-1:0] time_cursor = '0;
    bit                src_idle = 1'b0;
    bit                hold_request = 1'b0;

    heartbeat_arrival_estimator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_in   (frame_ch),
        .result_out (result_ch)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    function automatic frame_t heartbeat(logic [SEQ_W-1:0] seq_no, logic [TIME_W-1:0] stamp);
        frame_t f;
        f.len    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(50, 1518));
        f.etype  = ETHER_TYPE_IPV4;
        f.proto  = IP_PROTO_UDP;
        f.dport  = cur_port;
        f.seq_no = seq_no;
        f.stamp  = stamp;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        logic [32:0] next_seq;
        logic [TIME_W-1:0] stamp;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            // fresh heartbeat, kept below the top of the sequence space
            next_seq = seq_cursor + 33'(($urandom_range(0, 99) == 0) ?
                       $urandom_range(1, 1 << 26) : $urandom_range(1, 1 << 20));
            if (next_seq > 33'h0_FFFF_0000)
                next_seq = seq_cursor;
            seq_cursor = next_seq;
            if ($urandom_range(0, 9) == 0)
                stamp = {$urandom, $urandom};
            else
            begin
                time_cursor += 64'($urandom_range(1000, 2000000));
                stamp = time_cursor;
            end
            f = heartbeat(seq_cursor[31:0], stamp);
        end
        else if (pick < 82)
        begin
            // stale heartbeat: repeated or older sequence
            f = heartbeat($urandom_range(0, 1) ? seq_cursor[31:0] :
                          $urandom_range(0, seq_cursor[31:0]), {$urandom, $urandom});
        end
        else if (pick < 95)
        begin
            // near miss: one heartbeat condition broken
            f = heartbeat($urandom, {$urandom, $urandom});
            case ($urandom_range(0, 3))
                0: f.len   = 16'($urandom_range(0, 49));
                1: f.etype = ETHER_TYPE_IPV4 ^ 16'($urandom_range(1, 65535));
                2: f.proto = IP_PROTO_UDP ^ 8'($urandom_range(1, 255));
                default: f.dport = cur_port ^ 16'($urandom_range(1, 65535));
            endcase
        end
        else
        begin
            f.len    = 16'($urandom);
            f.etype  = 16'($urandom);
            f.proto  = 8'($urandom);
            f.dport  = 16'($urandom);
            f.seq_no = $urandom;
            f.stamp  = {$urandom, $urandom};
        end
        return f;
    endfunction

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_frame(frame_t f);
        int gap;
        gap = src_idle ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.frame_length       <= f.len;
        frame_ch.ether_type         <= f.etype;
        frame_ch.ip_protocol        <= f.proto;
        frame_ch.udp_dest_port      <= f.dport;
        frame_ch.heartbeat_sequence <= f.seq_no;
        frame_ch.arrival_time_ns    <= f.stamp;
        frame_ch.valid              <= 1'b1;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        board.take_frame(f);
        @(negedge clk);
    endtask

    task automatic run_random(int count, int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i % 64 == 0)
                src_idle = $urandom_range(0, 1);
            if (i == hold_at)
            begin
                src_idle     = 1'b0;
                hold_request = 1'b1;
            end
            send_frame(random_frame());
        end
    endtask

    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(bit write, logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= PORT_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_port(logic [15:0] value);
        logic [31:0] rd;
        apb_access(1'b1, {16'b0, value}, rd);
        board.port = value;
        cur_port   = value;
        apb_access(1'b0, '0, rd);
        if (rd !== {16'b0, value})
            board.report($sformatf("watched port reads %h, expected %h", rd, value));
    endtask

    task automatic directed_opening();
        frame_t f;
        f = heartbeat(32'd9, 64'd5);
        f.len = 16'd49;                        // one byte short of a heartbeat
        send_frame(f);
        f = heartbeat(32'd9, 64'd5);
        f.etype = 16'h0801;
        send_frame(f);
        f = heartbeat(32'd9, 64'd5);
        f.proto = 8'd6;
        send_frame(f);
        f = heartbeat(32'd9, 64'd5);
        f.dport = cur_port + 16'd1;
        send_frame(f);
        f = heartbeat('0, '0);
        f.len   = '0;
        f.etype = '0;
        f.proto = '0;
        f.dport = '0;
        send_frame(f);
        f = heartbeat('1, '1);
        f.len   = '1;
        f.etype = '1;
        f.proto = '1;
        f.dport = '1;
        send_frame(f);
        // first heartbeat is taken even with sequence zero
        f = heartbeat(32'd0, 64'hFFFF_FFFF_FFFF_FFF0);
        f.len = 16'hFFFF;
        send_frame(f);
        send_frame(heartbeat(32'd0, 64'd7));
        f = heartbeat(32'd1, 64'h40);          // partial sum wraps
        f.len = 16'd50;
        send_frame(f);
        send_frame(heartbeat(32'd1, 64'd9));
        send_frame(heartbeat(32'd3, 64'd0));
        send_frame(heartbeat(32'd2, 64'd123));
        send_frame(heartbeat(32'd4, '1));
        send_frame(heartbeat(32'd5, 64'd100)); // window full, first average
        send_frame(heartbeat(32'd6, 64'd0));
        send_frame(heartbeat(32'd7, 64'd0));   // older than the slot it replaces
        send_frame(heartbeat(32'd8, 64'h8000_0000_0000_0000));
        seq_cursor  = 33'd8;
        time_cursor = 64'd1000000;
    endtask

    task automatic directed_closing();
        send_frame(heartbeat(32'hFFFF_FFFF, {$urandom, $urandom}));
        send_frame(heartbeat(32'hFFFF_FFFF, {$urandom, $urandom}));
        send_frame(heartbeat(32'h0000_0000, {$urandom, $urandom}));
    endtask

    initial
    begin : result_sink
        int stall;
        int seen;
        bit sink_idle;
        frame_result_t got;
        result_ch.ready = 1'b0;
        seen = 0;
        sink_idle = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (seen % 50 == 0)
                sink_idle = $urandom_range(0, 1);
            if (hold_request)
            begin
                // long back-pressure so the pipeline fills and the input stalls
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                stall = sink_idle ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            got.drop      = result_ch.drop_frame;
            got.taken     = result_ch.heartbeat_accepted;
            got.est_valid = result_ch.estimate_valid;
            got.estimate  = result_ch.arrival_estimate_ns;
            board.match_result(got);
            seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", quiet);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] rd;
        board   = new();
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        frame_ch.valid              = 1'b0;
        frame_ch.frame_length       = '0;
        frame_ch.ether_type         = '0;
        frame_ch.ip_protocol        = '0;
        frame_ch.udp_dest_port      = '0;
        frame_ch.heartbeat_sequence = '0;
        frame_ch.arrival_time_ns    = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_access(1'b0, '0, rd);
        if (rd !== {16'b0, WATCH_PORT_RESET})
            board.report($sformatf("watched port after reset reads %h", rd));
        directed_opening();
        drain();

        set_port(16'h0000);
        run_random(PHASE_ITEMS, -1);
        drain();
        set_port(16'hFFFF);
        run_random(PHASE_ITEMS, -1);
        drain();
        set_port(16'($urandom_range(1, 65534)));
        run_random(PHASE_ITEMS, 100);
        drain();
        set_port(WATCH_PORT_RESET);
        run_random(PHASE_ITEMS, -1);
        directed_closing();
        drain();

        $display("covered %0d frames: %0d heartbeats taken, %0d stale heartbeats, %0d passed on",
                 board.frames, board.taken, board.rejected, board.passed);
        $display("%0d window slides across four port settings, one long result stall included",
                 board.slides);
        if (board.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
rtl/hae_pkg.sv
rtl/hae_in_if.sv
rtl/hae_out_if.sv
rtl/hae_front.sv
rtl/hae_div.sv
rtl/hae_tail.sv
rtl/heartbeat_arrival_estimator.sv
tb/heartbeat_arrival_estimator_test.sv
